/* hdl/alrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alrp_pkg: shared types and constants of the text light-list parser
// Character codes, register indexes, field positions and the result
// record that travels from the parse core to the output buffer.
// ----------------------------------------------------------------------------
package alrp_pkg;

	// Field widths
	localparam int CHAR_W   = 8;
	localparam int COUNT_W  = 11;
	localparam int INDEX_W  = 10;
	localparam int COLOR_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;

	// Separator and digit characters
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_COUNT = 3'd0,
		REG_BG_RED      = 3'd1,
		REG_BG_GREEN    = 3'd2,
		REG_BG_BLUE     = 3'd3
	} reg_idx_t;

	// Next number expected within a light
	typedef enum logic [1:0] {
		FLD_RED   = 2'd0,
		FLD_GREEN = 2'd1,
		FLD_BLUE  = 2'd2,
		FLD_ALPHA = 2'd3
	} field_t;

	// Configuration register set
	typedef struct packed {
		logic [COUNT_W-1:0] light_count;
		logic [COLOR_W-1:0] bg_red;
		logic [COLOR_W-1:0] bg_green;
		logic [COLOR_W-1:0] bg_blue;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic               light_valid;
		logic [INDEX_W-1:0] light_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               array_done;
		logic               ended_short;
	} res_t;

endpackage

/* hdl/alrp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alrp_core: per-character parse step
// Holds the number accumulator, field position, held colour and light
// counter; decides combinationally whether the registered item yields a result.
// ----------------------------------------------------------------------------
module alrp_core import alrp_pkg::*; #(
	parameter int MAX_LIGHTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [CHAR_W-1:0] char_s1,
	input  logic              eod_s1,
	input  cfg_t              cfg,
	output logic              got,
	output res_t              res
);

	localparam logic [31:0] MaxLim = 32'(MAX_LIGHTS);

	logic [COLOR_W-1:0] number_q;
	logic               in_number_q;
	field_t             field_q;
	logic [COLOR_W-1:0] held_r_q, held_g_q, held_b_q;
	logic [COUNT_W-1:0] lights_q;

	logic               is_sep;
	logic [COLOR_W-1:0] digit;
	logic [COLOR_W-1:0] accum;
	logic               finish;
	logic               finish_light;
	logic               alpha_zero;
	logic [COUNT_W-1:0] eff_count;
	logic [COUNT_W-1:0] lights_next;
	logic               arr_done;

	// Character classification and decimal accumulate (x10 = x8 + x2)
	assign is_sep = (char_s1 == CH_SPACE) || (char_s1 == CH_LF) ||
	                (char_s1 == CH_CR) || (char_s1 == CH_TAB);
	assign digit  = char_s1 - CH_ZERO;
	assign accum  = {number_q[4:0], 3'b000} + {number_q[6:0], 1'b0} + digit;

	// A pending number ends on a separator or on end of data
	assign finish       = in_number_q && (eod_s1 || is_sep);
	assign finish_light = finish && (field_q == FLD_ALPHA);
	assign alpha_zero   = (number_q == '0);

	// Lights per array, clamped to 1..MAX_LIGHTS
	always_comb begin
		if (cfg.light_count == '0) begin
			eff_count = COUNT_W'(1);
		end else if ({21'd0, cfg.light_count} > MaxLim) begin
			eff_count = MaxLim[COUNT_W-1:0];
		end else begin
			eff_count = cfg.light_count;
		end
	end

	assign lights_next = lights_q + COUNT_W'(1);
	assign arr_done    = finish_light && (lights_next >= eff_count);

	// Result record
	always_comb begin
		res = '0;
		if (finish_light) begin
			res.light_valid = 1'b1;
			res.light_index = lights_q[INDEX_W-1:0];
			res.red         = alpha_zero ? cfg.bg_red   : held_r_q;
			res.green       = alpha_zero ? cfg.bg_green : held_g_q;
			res.blue        = alpha_zero ? cfg.bg_blue  : held_b_q;
			res.array_done  = arr_done;
		end
		res.ended_short = eod_s1 && !arr_done;
	end

	assign got = eod_s1 || finish_light;

	// Parse control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_q    <= '0;
			in_number_q <= 1'b0;
			field_q     <= FLD_RED;
			lights_q    <= '0;
		end else if (fire) begin
			if (eod_s1) begin
				number_q    <= '0;
				in_number_q <= 1'b0;
				field_q     <= FLD_RED;
				lights_q    <= '0;
			end else if (!is_sep) begin
				number_q    <= in_number_q ? accum : digit;
				in_number_q <= 1'b1;
			end else if (in_number_q) begin
				number_q    <= '0;
				in_number_q <= 1'b0;
				if (field_q == FLD_ALPHA) begin
					field_q  <= FLD_RED;
					lights_q <= arr_done ? '0 : lights_next;
				end else begin
					field_q <= field_t'(field_q + 2'd1);
				end
			end
		end
	end

	// Held colour of the light being read
	always_ff @(posedge clk) begin
		if (fire && !eod_s1 && is_sep && in_number_q) begin
			unique case (field_q)
				FLD_RED:   held_r_q <= number_q;
				FLD_GREEN: held_g_q <= number_q;
				FLD_BLUE:  held_b_q <= number_q;
				FLD_ALPHA: ;
				default:   ;
			endcase
		end
	end

endmodule

/* hdl/alrp_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alrp_outq: two-entry result buffer
// Output register plus a skid entry, so the stall toward the input side is
// taken from a register and not from the downstream stall.
// ----------------------------------------------------------------------------
module alrp_outq import alrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic out_stall,
	output logic out_valid,
	output res_t out_data,
	output logic full
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop       = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = skid_valid_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q && !pop || (skid_valid_q && pop);
			end else if (pop) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	// Payload movement
	always_ff @(posedge clk) begin
		if (push) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

/* hdl/ascii_rgba_light_list_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_rgba_light_list_parser: text light-list parser, top level
// Configuration registers, input register, parse core and result buffer.
// ----------------------------------------------------------------------------
// The parser takes one character per clock. An accepted item is registered
// in the input register and parsed from there when the result buffer is not
// full; its result, if any, is written to the buffer's output register and
// shown on the output from that register. Throughput is one item per clock for
// as long as results are taken; a two-entry result buffer absorbs output
// stalls, and in_stall rises only when that buffer is full and an item is
// waiting in the input register. Whitespace-free runs of bytes form numbers,
// every four numbers form a light, and only a completed light or an end of
// data produces a result. Configuration is taken at any time (cfg_ready is
// always high) and should be written while the parser is idle.
// ----------------------------------------------------------------------------
module ascii_rgba_light_list_parser import alrp_pkg::*; #(
	parameter int MAX_LIGHTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic                  end_of_data,
	// Result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  light_valid,
	output logic [INDEX_W-1:0]    light_index,
	output logic [COLOR_W-1:0]    red,
	output logic [COLOR_W-1:0]    green,
	output logic [COLOR_W-1:0]    blue,
	output logic                  array_done,
	output logic                  ended_short,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              s1_valid_q;
	logic [CHAR_W-1:0] char_s1;
	logic              eod_s1;
	logic              q_full;
	logic              fire;
	logic              accept;
	logic              got;
	res_t              core_res;
	res_t              out_res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_count <= COUNT_W'(1);
			cfg_q.bg_red      <= '0;
			cfg_q.bg_green    <= '0;
			cfg_q.bg_blue     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIGHT_COUNT: cfg_q.light_count <= cfg_data;
				REG_BG_RED:      cfg_q.bg_red      <= cfg_data[COLOR_W-1:0];
				REG_BG_GREEN:    cfg_q.bg_green    <= cfg_data[COLOR_W-1:0];
				REG_BG_BLUE:     cfg_q.bg_blue     <= cfg_data[COLOR_W-1:0];
				default:         ;
			endcase
		end
	end

	// Input register
	assign fire     = s1_valid_q && !q_full;
	assign in_stall = s1_valid_q && q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			eod_s1  <= end_of_data;
		end
	end

	// Parse step
	alrp_core #(
		.MAX_LIGHTS(MAX_LIGHTS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.char_s1 (char_s1),
		.eod_s1  (eod_s1),
		.cfg     (cfg_q),
		.got     (got),
		.res     (core_res)
	);

	// Result buffer
	alrp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && got),
		.push_data (core_res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.full      (q_full)
	);

	assign light_valid = out_res.light_valid;
	assign light_index = out_res.light_index;
	assign red         = out_res.red;
	assign green       = out_res.green;
	assign blue        = out_res.blue;
	assign array_done  = out_res.array_done;
	assign ended_short = out_res.ended_short;

endmodule

/* sim/ascii_rgba_light_list_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_rgba_light_list_parser_tb: self-checking bench for the light parser
// Streams text through the parser under random input gaps and output stalls.
// A behavioral parser in the bench predicts each light and each end-of-data
// record, and every delivered item is checked field by field against the
// oldest prediction. Registers are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module ascii_rgba_light_list_parser_tb;
	import alrp_pkg::*;

	localparam int MAX_LIGHTS   = 1024;
	localparam int CFG_REGS     = 4;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 212;
	localparam int DRAIN_CYCLES = 8;
	localparam int WAIT_LIMIT   = 50000;
	localparam int PRINT_LIMIT  = 200;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              eod;
	} text_item_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	// DUT ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CHAR_W-1:0]     char_code = '0;
	logic                  end_of_data = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  light_valid;
	logic [INDEX_W-1:0]    light_index;
	logic [COLOR_W-1:0]    red;
	logic [COLOR_W-1:0]    green;
	logic [COLOR_W-1:0]    blue;
	logic                  array_done;
	logic                  ended_short;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted parser state and register copy
	cfg_t               regs_m;
	logic [COLOR_W-1:0] num_acc;
	logic               num_open;
	field_t             fld;
	logic [COLOR_W-1:0] held [3];
	logic [INDEX_W-1:0] lights_in_array;

	res_t       results_due[$];
	text_item_t chars_to_send[$];

	// Bench bookkeeping
	logic        in_taken = 1'b0;
	int          gap_left = 0;
	int          burst_left = 1;
	int          seg_left = 0;
	stall_mode_t seg_mode = STALL_NONE;
	int          err_count = 0;
	int          n_pushed = 0;
	int          n_in = 0;
	int          n_results = 0;
	int          n_lights = 0;
	int          n_bg = 0;
	int          n_arrays = 0;
	int          n_short = 0;

	ascii_rgba_light_list_parser #(.MAX_LIGHTS(MAX_LIGHTS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.end_of_data (end_of_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.light_valid (light_valid),
		.light_index (light_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.array_done  (array_done),
		.ended_short (ended_short),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(string what, longint unsigned got_v, longint unsigned want_v);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got_v, want_v);
	endtask

	// ------------------------------------------------------------------------
	// Light parser prediction
	// ------------------------------------------------------------------------
	task automatic clear_parse_state();
		num_acc = '0;
		num_open = 1'b0;
		fld = FLD_RED;
		held[0] = '0;
		held[1] = '0;
		held[2] = '0;
		lights_in_array = '0;
	endtask

	function automatic int lights_per_array();
		int n;
		n = regs_m.light_count;
		if (n == 0) n = 1;
		if (n > MAX_LIGHTS) n = MAX_LIGHTS;
		return n;
	endfunction

	function automatic logic is_separator(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
	endfunction

	// Close the pending number; a closed alpha yields a light
	task automatic close_number(output res_t r, output logic got, output logic done);
		logic [COLOR_W-1:0] v;
		int nxt;
		v = num_acc;
		num_open = 1'b0;
		num_acc = '0;
		r = '0;
		got = 1'b0;
		done = 1'b0;
		if (fld != FLD_ALPHA) begin
			held[fld] = v;
			fld = field_t'(fld + 1);
		end else begin
			fld = FLD_RED;
			if (v == '0) begin
				held[0] = regs_m.bg_red;
				held[1] = regs_m.bg_green;
				held[2] = regs_m.bg_blue;
				n_bg++;
			end
			nxt = int'(lights_in_array) + 1;
			done = nxt >= lights_per_array();
			r.light_valid = 1'b1;
			r.light_index = lights_in_array;
			r.red = held[0];
			r.green = held[1];
			r.blue = held[2];
			r.array_done = done;
			lights_in_array = done ? '0 : nxt[INDEX_W-1:0];
			got = 1'b1;
			n_lights++;
			if (done) n_arrays++;
		end
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic eod);
		res_t r;
		logic got;
		logic done;
		logic [COLOR_W-1:0] dig;
		r = '0;
		got = 1'b0;
		done = 1'b0;
		if (eod) begin
			// end of data: flush, report, back to reset state
			if (num_open) close_number(r, got, done);
			if (!got) r = '0;
			r.ended_short = !(got && done);
			if (r.ended_short) n_short++;
			clear_parse_state();
			results_due.push_back(r);
		end else if (is_separator(c)) begin
			if (num_open) begin
				close_number(r, got, done);
				if (got) results_due.push_back(r);
			end
		end else begin
			// any other byte is a digit, wrapping mod 256
			dig = c - CH_ZERO;
			num_acc = num_open ? num_acc * 8'd10 + dig : dig;
			num_open = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Text generation
	// ------------------------------------------------------------------------
	task automatic put_byte(input logic [CHAR_W-1:0] c);
		chars_to_send.push_back('{code: c, eod: 1'b0});
		n_pushed++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_eod();
		chars_to_send.push_back('{code: CHAR_W'($urandom_range(0, 255)), eod: 1'b1});
		n_pushed++;
	endtask

	task automatic put_seps();
		int k;
		k = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
		repeat (k) begin
			case ($urandom_range(0, 3))
				0: put_byte(CH_SPACE);
				1: put_byte(CH_LF);
				2: put_byte(CH_CR);
				default: put_byte(CH_TAB);
			endcase
		end
	endtask

	// Decimal number; alpha often zero, sometimes wrapped or zero-padded
	task automatic put_number(input logic alpha);
		int v;
		string s;
		if (alpha && $urandom_range(0, 2) == 0) v = 256 * $urandom_range(0, 3);
		else if ($urandom_range(0, 9) == 0) v = $urandom_range(256, 99999);
		else v = $urandom_range(0, 255);
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0) s = {"0", s};
		put_text(s);
		put_seps();
	endtask

	task automatic gen_random(input int n);
		int base;
		base = n_pushed;
		while (n_pushed - base < n) begin
			case ($urandom_range(0, 99)) inside
				[0:77]: begin
					repeat (3) put_number(1'b0);
					put_number(1'b1);
				end
				[78:85]: begin
					put_byte(CHAR_W'($urandom_range(0, 255)));
					if ($urandom_range(0, 1)) put_seps();
				end
				[86:92]: put_eod();
				default: begin
					repeat ($urandom_range(1, 3)) put_number(1'b0);
					put_eod();
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// Configuration writes; called at a falling edge, returns at one
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LIGHT_COUNT: regs_m.light_count = d;
			REG_BG_RED:      regs_m.bg_red = d[COLOR_W-1:0];
			REG_BG_GREEN:    regs_m.bg_green = d[COLOR_W-1:0];
			REG_BG_BLUE:     regs_m.bg_blue = d[COLOR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_phase_regs(input int cnt, input int shade);
		logic [CFG_DATA_W-1:0] hi;
		hi = CFG_DATA_W'($urandom_range(0, 7)) << COLOR_W;
		// out-of-range index first; must be ignored
		write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_REGS)),
			CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
		write_reg(REG_LIGHT_COUNT, CFG_DATA_W'(cnt));
		if (shade < 0) begin
			write_reg(REG_BG_RED, CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
			write_reg(REG_BG_GREEN, CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
			write_reg(REG_BG_BLUE, CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
		end else begin
			write_reg(REG_BG_RED, hi | CFG_DATA_W'(shade));
			write_reg(REG_BG_GREEN, hi | CFG_DATA_W'(shade));
			write_reg(REG_BG_BLUE, hi | CFG_DATA_W'(shade));
		end
		cfg_valid <= 1'b0;
	endtask

	// Wait until all text is taken and all results are in, then settle
	task automatic wait_idle();
		int n;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while (n < WAIT_LIMIT &&
			(chars_to_send.size() != 0 || in_valid || results_due.size() != 0));
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Text driver: bursts of items with random gaps
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		text_item_t it;
		logic nv;
		if (arst_n && (!in_valid || in_taken)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (chars_to_send.size() != 0) begin
				it = chars_to_send.pop_front();
				nv = 1'b1;
				char_code <= it.code;
				end_of_data <= it.eod;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left--;
				end
			end
			in_valid <= nv;
		end
	end

	// Result stall: segments of no stall, random, heavy and periodic stalling
	always @(negedge clk) begin
		logic st;
		if (seg_left == 0) begin
			seg_mode = stall_mode_t'($urandom_range(0, 3));
			seg_left = $urandom_range(16, 160);
		end else begin
			seg_left--;
		end
		case (seg_mode)
			STALL_NONE:  st = 1'b0;
			STALL_LIGHT: st = $urandom_range(0, 1);
			STALL_HEAVY: st = $urandom_range(0, 3) != 0;
			default:     st = (seg_left % 8) >= 4;
		endcase
		out_stall <= st;
	end

	// ------------------------------------------------------------------------
	// Monitor: check delivered results, predict from accepted items
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		res_t got_r;
		res_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_r = {light_valid, light_index, red, green, blue, array_done, ended_short};
				n_results++;
				if (results_due.size() == 0) begin
					report("result with none pending", got_r, 0);
				end else begin
					want = results_due.pop_front();
					if (got_r.light_valid != want.light_valid)
						report("light_valid", got_r.light_valid, want.light_valid);
					if (got_r.light_index != want.light_index)
						report("light_index", got_r.light_index, want.light_index);
					if (got_r.red != want.red) report("red", got_r.red, want.red);
					if (got_r.green != want.green) report("green", got_r.green, want.green);
					if (got_r.blue != want.blue) report("blue", got_r.blue, want.blue);
					if (got_r.array_done != want.array_done)
						report("array_done", got_r.array_done, want.array_done);
					if (got_r.ended_short != want.ended_short)
						report("ended_short", got_r.ended_short, want.ended_short);
				end
			end
			if (in_valid && !in_stall) begin
				n_in++;
				parse_char(char_code, end_of_data);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int cnt_tab [PHASES];
		int shade;
		regs_m.light_count = 1;
		regs_m.bg_red = '0;
		regs_m.bg_green = '0;
		regs_m.bg_blue = '0;
		clear_parse_state();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: one light per array, distinct background per channel
		write_reg(REG_LIGHT_COUNT, CFG_DATA_W'(1));
		write_reg(REG_BG_RED, CFG_DATA_W'(8'hA5));
		write_reg(REG_BG_GREEN, CFG_DATA_W'(8'h5A));
		write_reg(REG_BG_BLUE, CFG_DATA_W'(8'hC3));
		cfg_valid <= 1'b0;
		// leading separators, max value, wrap to zero, zero alpha
		put_byte(CH_SPACE);
		put_byte(CH_LF);
		put_text("255 0");
		put_byte(CH_TAB);
		put_text("256");
		put_byte(CH_CR);
		put_text("0 ");
		// end right after a completed array
		put_eod();
		// non-digit byte as a digit, partial light dropped at end
		put_text("A 7");
		put_eod();
		// end flushes the pending alpha and completes the array
		put_text("1 2 3 9");
		put_eod();
		wait_idle();

		// Random phases over count extremes, clamping and background shades
		cnt_tab = '{0, 2, 2047, 1, 3, 1024, 4, 2};
		cnt_tab[6] = $urandom_range(4, 12);
		for (int p = 0; p < PHASES; p++) begin
			shade = (p == 1) ? 0 : (p == 3) ? 255 : -1;
			set_phase_regs(cnt_tab[p], shade);
			gen_random(PHASE_ITEMS);
			if (p == PHASES - 1 || $urandom_range(0, 1)) put_eod();
			wait_idle();
		end

		if (results_due.size() != 0)
			report("results never delivered", results_due.size(), 0);
		$display("Sent %0d text items, checked %0d results under random gaps and stalls.",
			n_in, n_results);
		$display("Lights %0d (%0d on background), arrays done %0d, short ends %0d.",
			n_lights, n_bg, n_arrays, n_short);
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
